@@ src/rps_pkg.sv @@
// Shared constants and types of the rectangular plane-stress stiffness block.
`default_nettype none
package rps_pkg;
	localparam int IN_FRAC_BITS  = 16;
	localparam int OUT_FRAC_BITS = 24;
	localparam int H_FRAC        = 15;
	localparam int G_FRAC        = 32;
	localparam int INV_FRAC      = 30;
	localparam int MU_SHIFT      = 17;
	localparam int H_SHIFT       = IN_FRAC_BITS + INV_FRAC - H_FRAC;
	localparam int E_SHIFT       = H_FRAC + G_FRAC - OUT_FRAC_BITS;
	localparam logic [16:0] NU_ONE = 17'h10000;

	// Per-element terms handed from the front end to the entry generator.
	typedef struct packed {
		logic [63:0] c;
		logic [63:0] d;
		logic [63:0] cmu;
		logic [63:0] dmu;
		logic [63:0] h;
		logic [14:0] p;
		logic        bad;
	} par_t;
endpackage
`default_nettype wire

@@ src/rps_front.sv @@
// Front end: takes an element word and derives c, d, mu*c, mu*d and the scale H.
`default_nettype none
module rps_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic signed [31:0] x_lower_left,
	input  logic signed [31:0] x_lower_right,
	input  logic signed [31:0] y_lower_left,
	input  logic signed [31:0] y_upper_left,
	input  logic [14:0]        poisson_ratio,
	input  logic [31:0]        young_modulus,
	input  logic [31:0]        plate_thickness,
	output logic               push,
	input  logic               full,
	output rps_pkg::par_t      par
);
	import rps_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_SETUP, ST_DIV, ST_ROUND, ST_MUL1, ST_MUL2, ST_PUSH
	} state_t;

	state_t      state_q;
	logic [5:0]  cnt_q;
	logic [32:0] a_q, b_q;
	logic        bad_q;
	logic [14:0] p_q;
	logic [31:0] e_q, th_q;
	logic [63:0] eth_q;
	logic [63:0] numc_q, numd_q, numi_q;
	logic [35:0] remc_q, remd_q, remi_q;
	logic [34:0] dvc_q, dvd_q, dvi_q;
	logic [63:0] quoc_q, quod_q, quoi_q;
	logic [63:0] c_q, d_q;
	logic [30:0] inv_q;
	logic [48:0] pc0_q, pc1_q, pd0_q, pd1_q;
	logic [62:0] ph0_q, ph1_q;
	par_t        par_q;

	logic [32:0] a_w, b_w;
	logic        accept;
	logic [36:0] stc, stdd, sti;
	logic [29:0] pp_w;
	logic [32:0] den_w;
	logic [16:0] m_w;
	logic [95:0] sumc_w, sumd_w;
	logic [127:0] sumh_w;

	// One restoring division step: returns the quotient bit and the new remainder.
	function automatic logic [36:0] dstep(input logic [35:0] rem, input logic nb,
			input logic [34:0] dv);
		logic [35:0] r;
		r = {rem[34:0], nb};
		if (r >= {1'b0, dv}) begin
			return {1'b1, r - {1'b0, dv}};
		end
		return {1'b0, r};
	endfunction

	assign a_w = {x_lower_right[31], x_lower_right} - {x_lower_left[31], x_lower_left};
	assign b_w = {y_upper_left[31], y_upper_left} - {y_lower_left[31], y_lower_left};
	assign accept = item_valid && !item_stall;
	assign item_stall = (state_q != ST_IDLE);
	assign push = (state_q == ST_PUSH) && !full;
	assign par = par_q;

	assign stc = dstep(remc_q, numc_q[63], dvc_q);
	assign stdd = dstep(remd_q, numd_q[63], dvd_q);
	assign sti = dstep(remi_q, numi_q[63], dvi_q);
	assign pp_w = p_q * p_q;
	assign den_w = 33'h1_0000_0000 - {3'b0, pp_w};
	assign m_w = NU_ONE - {2'b0, p_q};

	assign sumc_w = {47'b0, pc0_q} + {15'b0, pc1_q, 32'b0} + (96'd1 << (MU_SHIFT - 1));
	assign sumd_w = {47'b0, pd0_q} + {15'b0, pd1_q, 32'b0} + (96'd1 << (MU_SHIFT - 1));
	assign sumh_w = {65'b0, ph0_q} + {33'b0, ph1_q, 32'b0} + (128'd1 << (H_SHIFT - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					state_q <= ST_DIV;
					cnt_q <= '0;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (&cnt_q) begin
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: state_q <= ST_MUL1;
				ST_MUL1:  state_q <= ST_MUL2;
				ST_MUL2:  state_q <= ST_PUSH;
				ST_PUSH: begin
					if (!full) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			a_q <= a_w;
			b_q <= b_w;
			bad_q <= a_w[32] || (a_w == '0) || b_w[32] || (b_w == '0);
			p_q <= poisson_ratio;
			e_q <= young_modulus;
			th_q <= plate_thickness;
		end
		case (state_q)
			ST_SETUP: begin
				eth_q <= e_q * th_q;
				numc_q <= {a_q[31:0], 32'b0};
				numd_q <= {b_q[31:0], 32'b0};
				numi_q <= 64'h4000_0000_0000_0000;
				dvc_q <= {1'b0, b_q[31:0], 2'b0} + {2'b0, b_q[31:0], 1'b0};
				dvd_q <= {1'b0, a_q[31:0], 2'b0} + {2'b0, a_q[31:0], 1'b0};
				dvi_q <= {2'b0, den_w};
				remc_q <= '0;
				remd_q <= '0;
				remi_q <= '0;
				quoc_q <= '0;
				quod_q <= '0;
				quoi_q <= '0;
			end
			ST_DIV: begin
				numc_q <= {numc_q[62:0], 1'b0};
				numd_q <= {numd_q[62:0], 1'b0};
				numi_q <= {numi_q[62:0], 1'b0};
				remc_q <= stc[35:0];
				remd_q <= stdd[35:0];
				remi_q <= sti[35:0];
				quoc_q <= {quoc_q[62:0], stc[36]};
				quod_q <= {quod_q[62:0], stdd[36]};
				quoi_q <= {quoi_q[62:0], sti[36]};
			end
			ST_ROUND: begin
				// Round half up: bump the quotient when twice the remainder reaches the divisor.
				c_q <= quoc_q + {63'b0, ({remc_q[34:0], 1'b0} >= {1'b0, dvc_q})};
				d_q <= quod_q + {63'b0, ({remd_q[34:0], 1'b0} >= {1'b0, dvd_q})};
				inv_q <= quoi_q[30:0] + {30'b0, ({remi_q[34:0], 1'b0} >= {1'b0, dvi_q})};
			end
			ST_MUL1: begin
				pc0_q <= c_q[31:0] * m_w;
				pc1_q <= c_q[63:32] * m_w;
				pd0_q <= d_q[31:0] * m_w;
				pd1_q <= d_q[63:32] * m_w;
				ph0_q <= eth_q[31:0] * inv_q;
				ph1_q <= eth_q[63:32] * inv_q;
			end
			ST_MUL2: begin
				par_q.c <= c_q;
				par_q.d <= d_q;
				par_q.cmu <= sumc_w[MU_SHIFT + 63:MU_SHIFT];
				par_q.dmu <= sumd_w[MU_SHIFT + 63:MU_SHIFT];
				par_q.h <= (|sumh_w[127:H_SHIFT + 64]) ? '1 : sumh_w[H_SHIFT + 63:H_SHIFT];
				par_q.p <= p_q;
				par_q.bad <= bad_q;
			end
			default: begin
			end
		endcase
	end
endmodule
`default_nettype wire

@@ src/rps_queue.sv @@
// Two-entry queue of element terms between the front end and the entry generator.
`default_nettype none
module rps_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rps_pkg::par_t wdata,
	output logic          full,
	input  logic          pop,
	output rps_pkg::par_t head,
	output logic          avail
);
	import rps_pkg::*;

	par_t       mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign avail = (cnt_q != 2'd0);
	assign head = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end
endmodule
`default_nettype wire

@@ src/rps_back.sv @@
// Entry generator: walks the 64 matrix entries and scales each by H in a pipeline.
`default_nettype none
module rps_back (
	input  logic               clk,
	input  logic               arst_n,
	input  rps_pkg::par_t      head,
	input  logic               avail,
	output logic               pop,
	output logic               entry_valid,
	input  logic               entry_stall,
	output logic [2:0]         row_index,
	output logic [2:0]         col_index,
	output logic signed [63:0] entry_value,
	output logic               geometry_error,
	output logic               last_entry
);
	import rps_pkg::*;

	logic        adv, issue;
	logic [5:0]  k_q;
	logic        v_s1, v_s2, v_s3, v_s4, ov_q;

	logic [5:0]  idx_s1, idx_s2, idx_s3, idx_s4;
	logic        last_s1, last_s2, last_s3, last_s4;
	logic        bad_s1, bad_s2, bad_s3, bad_s4;
	logic [63:0] h_s1, h_s2;
	logic [63:0] g_s1;
	logic [63:0] mag_s2;
	logic        neg_s2, neg_s3, neg_s4;
	logic [63:0] pp00_s3, pp01_s3, pp10_s3, pp11_s3;
	logic [127:0] sum_s4;

	logic [2:0]  row_q, col_q;
	logic [63:0] val_q;
	logic        err_q, last_q;

	logic [1:0]  ni, nj;
	logic        xi, yi, xj, yj, dx, dy;
	logic [63:0] s_w, t_w, g_w;
	logic [63:0] mag_w, cap_w, val_w;
	logic        sat_w;

	// Times +-1 or +-2, wrapping in 64 bits.
	function automatic logic [63:0] scl(input logic [63:0] v, input logic neg,
			input logic dbl);
		logic [63:0] w;
		w = dbl ? {v[62:0], 1'b0} : v;
		return neg ? (64'd0 - w) : w;
	endfunction

	assign adv = !(ov_q && entry_stall);
	assign issue = adv && avail;
	assign pop = issue && (&k_q);

	// Node order is lower left, lower right, upper right, upper left.
	assign ni = k_q[5:4];
	assign nj = k_q[2:1];
	assign xi = ni[0] ^ ni[1];
	assign yi = ni[1];
	assign xj = nj[0] ^ nj[1];
	assign yj = nj[1];
	assign dx = xi ^ xj;
	assign dy = yi ^ yj;
	assign s_w = {35'b0, head.p, 14'b0};
	assign t_w = {34'b0, (NU_ONE - {2'b0, head.p}), 13'b0};

	always_comb begin
		case ({k_q[3], k_q[0]})
			2'b00:   g_w = scl(head.d, dx, !dy) + scl(head.cmu, dy, !dx);
			2'b11:   g_w = scl(head.c, dy, !dx) + scl(head.dmu, dx, !dy);
			2'b01:   g_w = scl(s_w, xi ^ yj, 1'b0) + scl(t_w, yi ^ xj, 1'b0);
			default: g_w = scl(s_w, xj ^ yi, 1'b0) + scl(t_w, yj ^ xi, 1'b0);
		endcase
	end

	assign sat_w = |sum_s4[127:E_SHIFT + 64];
	assign mag_w = sat_w ? '1 : sum_s4[E_SHIFT + 63:E_SHIFT];
	assign cap_w = (mag_w[63] && (|mag_w[62:0])) ? 64'h8000_0000_0000_0000 : mag_w;
	always_comb begin
		if (bad_s4) begin
			val_w = '0;
		end else if (neg_s4) begin
			val_w = 64'd0 - cap_w;
		end else begin
			val_w = mag_w[63] ? 64'h7FFF_FFFF_FFFF_FFFF : mag_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			ov_q <= 1'b0;
		end else if (adv) begin
			if (issue) begin
				k_q <= k_q + 6'd1;
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			ov_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s1 <= k_q;
			last_s1 <= &k_q;
			bad_s1 <= head.bad;
			h_s1 <= head.h;
			g_s1 <= g_w;

			idx_s2 <= idx_s1;
			last_s2 <= last_s1;
			bad_s2 <= bad_s1;
			h_s2 <= h_s1;
			neg_s2 <= g_s1[63];
			mag_s2 <= g_s1[63] ? (64'd0 - g_s1) : g_s1;

			idx_s3 <= idx_s2;
			last_s3 <= last_s2;
			bad_s3 <= bad_s2;
			neg_s3 <= neg_s2;
			pp00_s3 <= h_s2[31:0] * mag_s2[31:0];
			pp01_s3 <= h_s2[31:0] * mag_s2[63:32];
			pp10_s3 <= h_s2[63:32] * mag_s2[31:0];
			pp11_s3 <= h_s2[63:32] * mag_s2[63:32];

			idx_s4 <= idx_s3;
			last_s4 <= last_s3;
			bad_s4 <= bad_s3;
			neg_s4 <= neg_s3;
			sum_s4 <= {64'b0, pp00_s3} + {32'b0, pp01_s3, 32'b0} + {32'b0, pp10_s3, 32'b0}
				+ {pp11_s3, 64'b0} + (128'd1 << (E_SHIFT - 1));

			row_q <= idx_s4[5:3];
			col_q <= idx_s4[2:0];
			val_q <= val_w;
			err_q <= bad_s4;
			last_q <= last_s4;
		end
	end

	assign entry_valid = ov_q;
	assign row_index = row_q;
	assign col_index = col_q;
	assign entry_value = val_q;
	assign geometry_error = err_q;
	assign last_entry = last_q;
endmodule
`default_nettype wire

@@ src/rect_plane_stress_stiffness.sv @@
// Top level of the rectangular four-node plane-stress element stiffness block.
// Each element word yields 64 entry words, the 8x8 stiffness matrix in row-major
// order, one per cycle while an element is queued and the output is not stalled.
// The front end is paced by its 64-step shared-shift divider that forms a/(6b),
// b/(6a) and 1/(1-nu^2) side by side; a two-entry queue lets it work on the next
// element while the entry generator, a five-stage pipeline, emits the current one.
// Sustained element rate is therefore set by the front end. A non-positive side
// gives zero entries with geometry_error set.
`default_nettype none
module rect_plane_stress_stiffness (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic signed [31:0] x_lower_left,
	input  logic signed [31:0] x_lower_right,
	input  logic signed [31:0] y_lower_left,
	input  logic signed [31:0] y_upper_left,
	input  logic [14:0]        poisson_ratio,
	input  logic [31:0]        young_modulus,
	input  logic [31:0]        plate_thickness,
	output logic               entry_valid,
	input  logic               entry_stall,
	output logic [2:0]         row_index,
	output logic [2:0]         col_index,
	output logic signed [63:0] entry_value,
	output logic               geometry_error,
	output logic               last_entry
);
	import rps_pkg::*;

	par_t par, head;
	logic push, full, pop, avail;

	rps_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.x_lower_left(x_lower_left),
		.x_lower_right(x_lower_right),
		.y_lower_left(y_lower_left),
		.y_upper_left(y_upper_left),
		.poisson_ratio(poisson_ratio),
		.young_modulus(young_modulus),
		.plate_thickness(plate_thickness),
		.push(push),
		.full(full),
		.par(par)
	);

	rps_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wdata(par),
		.full(full),
		.pop(pop),
		.head(head),
		.avail(avail)
	);

	rps_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.avail(avail),
		.pop(pop),
		.entry_valid(entry_valid),
		.entry_stall(entry_stall),
		.row_index(row_index),
		.col_index(col_index),
		.entry_value(entry_value),
		.geometry_error(geometry_error),
		.last_entry(last_entry)
	);
endmodule
`default_nettype wire
